### src/htcp_pkg.sv
`default_nettype none
package htcp_pkg;
  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned KeyBitsDef = 16;
  localparam int unsigned FuncW      = 1;
  localparam int unsigned InKeyW     = 16;
  localparam int unsigned ValW       = 10;
  localparam int unsigned StatW      = 2;
  localparam int unsigned OutSlotW   = 4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [StatW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatW-1:0] ST_FOUND     = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic load;
    logic start_head;
    logic step_head;
    logic start_walk;
    logic step_walk;
    logic start_probe;
    logic step_probe;
    logic rd;
    logic wr_entry;
    logic wr_link;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic valid;
    logic homematch;
    logic keymatch;
    logic has_link;
    logic cnt_done;
  } sts_t;
endpackage
`default_nettype wire

### src/htcp_if.sv
`default_nettype none
interface htcp_in_if;
  import htcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [InKeyW-1:0] key;
  logic [ValW-1:0]   value;
  modport source (output valid, func, key, value, input ready);
  modport sink (input valid, func, key, value, output ready);
endinterface

interface htcp_out_if;
  import htcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [StatW-1:0]    status;
  logic [OutSlotW-1:0] slot;
  logic [ValW-1:0]     found_value;
  modport source (output valid, status, slot, found_value, input ready);
  modport sink (input valid, status, slot, found_value, output ready);
endinterface
`default_nettype wire

### src/htcp_datapath.sv
`default_nettype none
module htcp_datapath import htcp_pkg::*; #(
  parameter int unsigned Slots   = SlotsDef,
  parameter int unsigned KeyBits = KeyBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [InKeyW-1:0]  key_i,
  input  wire logic [ValW-1:0]    value_i,
  output sts_t                    sts_o,
  output logic [OutSlotW-1:0]     slot_o,
  output logic [ValW-1:0]         fval_o
);
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);

  logic [KeyBits-1:0] mem_key [Slots];
  logic [ValW-1:0]    mem_val [Slots];
  logic [IdxW-1:0]    mem_link[Slots];
  logic [Slots-1:0]   valid_q, link_q;

  logic               func_q;
  logic [KeyBits-1:0] key_q;
  logic [ValW-1:0]    val_q;
  logic [IdxW-1:0]    home_q, pos_q, end_q;
  logic [CntW-1:0]    cnt_q;
  logic [KeyBits-1:0] rkey_q;
  logic [ValW-1:0]    rval_q;
  logic [IdxW-1:0]    rlink_q;
  logic [IdxW-1:0]    pos_inc;
  logic [KeyBits-1:0] key_m;

  function automatic logic [IdxW-1:0] homef(input logic [KeyBits-1:0] k);
    logic [31:0] r;
    r = 32'(k) % Slots;
    return IdxW'(r);
  endfunction

  assign key_m   = KeyBits'(key_i);
  assign pos_inc = (32'(pos_q) == Slots - 1) ? '0 : pos_q + IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rkey_q  <= mem_key[pos_q];
      rval_q  <= mem_val[pos_q];
      rlink_q <= mem_link[pos_q];
    end
    if (cmd_i.wr_entry) begin
      mem_key[pos_q] <= key_q;
      mem_val[pos_q] <= val_q;
    end
    if (cmd_i.wr_link) mem_link[end_q] <= pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      link_q  <= '0;
    end else begin
      if (cmd_i.wr_entry) begin
        valid_q[pos_q] <= 1'b1;
        link_q[pos_q]  <= 1'b0;
      end
      if (cmd_i.wr_link) link_q[end_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_m;
      val_q  <= value_i;
      home_q <= homef(key_m);
      pos_q  <= homef(key_m);
      cnt_q  <= '0;
    end else if (cmd_i.start_head) begin
      cnt_q <= '0;
    end else if (cmd_i.step_head) begin
      pos_q <= pos_inc;
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.start_walk) begin
      cnt_q <= '0;
    end else if (cmd_i.step_walk) begin
      pos_q <= rlink_q;
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.start_probe) begin
      end_q <= pos_q;
      pos_q <= pos_inc;
      cnt_q <= CntW'(1);
    end else if (cmd_i.step_probe) begin
      pos_q <= pos_inc;
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.valid     = valid_q[pos_q];
  assign sts_o.has_link  = link_q[pos_q];
  assign sts_o.homematch = homef(rkey_q) == home_q;
  assign sts_o.keymatch  = rkey_q == key_q;
  assign sts_o.cnt_done  = 32'(cnt_q) >= Slots - 1;
  assign slot_o          = OutSlotW'(pos_q);
  assign fval_o          = rval_q;
endmodule
`default_nettype wire

### src/htcp_ctrl.sv
`default_nettype none
module htcp_ctrl import htcp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cmd_t                   cmd_o,
  input  wire sts_t              sts_i,
  output logic                   res_load_o,
  output logic [StatW-1:0]       res_status_o,
  output logic                   res_hit_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HRD   = 3'd1;
  localparam logic [2:0] S_HCHK  = 3'd2;
  localparam logic [2:0] S_WRD   = 3'd3;
  localparam logic [2:0] S_WCHK  = 3'd4;
  localparam logic [2:0] S_PCHK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ovalid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    res_load_o   = 1'b0;
    res_status_o = ST_FULL;
    res_hit_o    = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i && !ovalid_q) begin
        cmd_o.load = 1'b1;
        state_d    = S_HRD;
      end
      S_HRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_HCHK;
      end
      S_HCHK: begin
        if (!sts_i.valid) begin
          res_load_o = 1'b1;
          if (sts_i.func == FUNC_INSERT) begin
            cmd_o.wr_entry = 1'b1;
            res_status_o   = ST_INSERTED;
            res_hit_o      = 1'b1;
          end else begin
            res_status_o = ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end else if (sts_i.homematch) begin
          cmd_o.start_walk = 1'b1;
          state_d          = S_WCHK;
        end else if (sts_i.cnt_done) begin
          res_load_o   = 1'b1;
          res_status_o = (sts_i.func == FUNC_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          cmd_o.step_head = 1'b1;
          state_d         = S_HRD;
        end
      end
      S_WRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WCHK;
      end
      S_WCHK: begin
        if (sts_i.func == FUNC_SEARCH && sts_i.keymatch) begin
          res_load_o   = 1'b1;
          res_status_o = ST_FOUND;
          res_hit_o    = 1'b1;
          state_d      = S_DONE;
        end else if (!sts_i.has_link || sts_i.cnt_done) begin
          if (sts_i.func == FUNC_SEARCH && !sts_i.has_link) begin
            res_load_o   = 1'b1;
            res_status_o = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else if (sts_i.func == FUNC_SEARCH) begin
            cmd_o.step_walk = 1'b1;
            res_load_o      = 1'b1;
            res_status_o    = ST_NOT_FOUND;
            state_d         = S_DONE;
          end else begin
            cmd_o.start_probe = 1'b1;
            state_d           = S_PCHK;
          end
        end else begin
          cmd_o.step_walk = 1'b1;
          state_d         = S_WRD;
        end
      end
      S_PCHK: begin
        if (!sts_i.valid) begin
          cmd_o.wr_entry = 1'b1;
          cmd_o.wr_link  = 1'b1;
          res_load_o     = 1'b1;
          res_status_o   = ST_INSERTED;
          res_hit_o      = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.cnt_done) begin
          res_load_o   = 1'b1;
          res_status_o = ST_FULL;
          state_d      = S_DONE;
        end else begin
          cmd_o.step_probe = 1'b1;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load_o) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;

`ifndef SYNTH
  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> !ovalid_q) else $error("result overwrite");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> (state_q == S_DONE)) else $error("no done");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_link |-> cmd_o.wr_entry) else $error("link without entry");
`endif
endmodule
`default_nettype wire

### src/hash_table_chained_probe.sv
`default_nettype none
// chained hash table with linear probing for new chain members
// in: item with func (0 insert, 1 search), key, value; valid/ready
// out: item with status, slot, found_value; valid/ready
// one item at a time; each slot of the home probe is read, then checked;
// the chain head is then checked for the key, each further chain member
// is read and checked, and each slot of the insert probe is checked by its valid bit alone
// an empty home slot gives a valid result right after its read and check
// the next item is accepted in the cycle after the result is taken
// the single-port slot memory and the sequencer set the rate
// reset empties the table (valid and link bits cleared at once)
// a result waits in the output register until taken; no new item is
// accepted while a result is held
module hash_table_chained_probe import htcp_pkg::*; #(
  parameter int unsigned Slots   = SlotsDef,
  parameter int unsigned KeyBits = KeyBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  htcp_in_if.sink   in_i,
  htcp_out_if.source out_o
);
  cmd_t                cmd;
  sts_t                sts;
  logic [OutSlotW-1:0] dslot;
  logic [ValW-1:0]     dval;
  logic                res_load, res_hit;
  logic [StatW-1:0]    res_status;
  logic [StatW-1:0]    status_q;
  logic [OutSlotW-1:0] slot_q;
  logic [ValW-1:0]     fval_q;

  htcp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .res_load_o  (res_load),
    .res_status_o(res_status),
    .res_hit_o   (res_hit)
  );

  htcp_datapath #(.Slots(Slots), .KeyBits(KeyBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .func_i (in_i.func),
    .key_i  (in_i.key),
    .value_i(in_i.value),
    .sts_o  (sts),
    .slot_o (dslot),
    .fval_o (dval)
  );

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_status;
      slot_q   <= res_hit ? dslot : '0;
      fval_q   <= (res_status == ST_FOUND) ? dval : '0;
    end
  end

  assign out_o.status      = status_q;
  assign out_o.slot        = slot_q;
  assign out_o.found_value = fval_q;
endmodule
`default_nettype wire
